// File: hw/rtl/bts_pkg.sv
// bts_pkg: shared types and constants of the bilinear texture sampler
// no dependencies; imported by bilinear_texture_sampler_unit

package bts_pkg;

    // texture geometry
    localparam int TEX_SIZE   = 256;
    localparam int IDX_W      = $clog2(TEX_SIZE);
    localparam int FRAC_BITS  = 11;
    localparam int COORD_W    = 19;
    localparam int TEXEL_W    = 32;
    localparam int POS_W      = 8;

    // four banks split by row and column parity, so any 2x2 square hits each once
    localparam int NUM_BANKS  = 4;
    localparam int BANK_SEL_W = 2;
    localparam int BANK_AW    = 2 * IDX_W - 2;
    localparam int BANK_DEPTH = 1 << BANK_AW;

    // channel arithmetic widths
    localparam int NUM_CH     = 3;
    localparam int CH_W       = 8;
    localparam int N_W        = CH_W + FRAC_BITS;          // blended value, unsigned
    localparam int H_W        = N_W + 2;                   // horizontal blend, signed
    localparam int D_W        = N_W + 1;                   // vertical difference, signed
    localparam int P_W        = D_W + FRAC_BITS + 1;       // vertical product, signed

    // slave tdata layout, lowest field first
    localparam int WR_COL_LSB   = 0;
    localparam int WR_ROW_LSB   = WR_COL_LSB + POS_W;
    localparam int WR_TEXEL_LSB = WR_ROW_LSB + POS_W;
    localparam int COORD_X_LSB  = WR_TEXEL_LSB + TEXEL_W;
    localparam int COORD_Y_LSB  = COORD_X_LSB + COORD_W;
    localparam int S_DATA_USED  = COORD_Y_LSB + COORD_W;
    localparam int S_TDATA_W    = ((S_DATA_USED + 7) / 8) * 8;
    localparam int M_TDATA_W    = TEXEL_W;

    // item kinds carried on tuser
    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [FRAC_BITS-1:0] t_alpha;
    typedef logic [TEXEL_W-1:0]   t_texel;

endpackage

// File: hw/rtl/bilinear_texture_sampler_unit.sv
// bilinear_texture_sampler_unit: banked texture store and bilinear filter pipeline
// depends on bts_pkg

// Stores a wrapping 256x256 texture of 32-bit texels and filters it bilinearly.
// A beat with tuser = write stores wr_texel at (wr_col, wr_row) and gives no result;
// a beat with tuser = sample takes 8.11 fixed-point coordinates and returns one
// pixel beat, R/G/B in bits 23:16/15:8/7:0, or the texel whole when the four
// texels of the square are equal. One beat is taken every clock while the
// master side drains; a sample passes the bank read, stage 2, stage 3 and output
// registers. The texture sits in four single-port-read banks split by row and
// column parity, so the four texels of any square are read in the same cycle;
// a write is visible to the very next sample. Texels never written read as garbage.
module bilinear_texture_sampler_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // wr_col, wr_row, wr_texel, coord_x, coord_y, zero pad
    input  logic [bts_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // op
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pixel
    output logic [bts_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import bts_pkg::*;

    // input unpacking
    logic               s_acc;
    logic               adv;
    t_op                in_op;
    logic [POS_W-1:0]   in_col;
    logic [POS_W-1:0]   in_row;
    t_texel             in_texel;
    logic [COORD_W-1:0] in_cx;
    logic [COORD_W-1:0] in_cy;

    assign in_op    = t_op'(s_axis_tuser);
    assign in_col   = s_axis_tdata[WR_COL_LSB +: POS_W];
    assign in_row   = s_axis_tdata[WR_ROW_LSB +: POS_W];
    assign in_texel = s_axis_tdata[WR_TEXEL_LSB +: TEXEL_W];
    assign in_cx    = s_axis_tdata[COORD_X_LSB +: COORD_W];
    assign in_cy    = s_axis_tdata[COORD_Y_LSB +: COORD_W];

    // the whole pipeline moves together when the output stage can take a beat
    logic r_out_valid;
    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = adv;
    assign s_acc         = s_axis_tvalid && adv;

    // square pick per axis: first texel and weight
    t_idx   x0, x1, y0, y1;
    t_alpha ax, ay;
    always_comb begin
        if (in_cx[FRAC_BITS-1]) begin
            x0 = in_cx[FRAC_BITS +: IDX_W];
        end else begin
            x0 = in_cx[FRAC_BITS +: IDX_W] - t_idx'(1);
        end
        if (in_cy[FRAC_BITS-1]) begin
            y0 = in_cy[FRAC_BITS +: IDX_W];
        end else begin
            y0 = in_cy[FRAC_BITS +: IDX_W] - t_idx'(1);
        end
        x1 = x0 + t_idx'(1);
        y1 = y0 + t_idx'(1);
        ax = {~in_cx[FRAC_BITS-1], in_cx[FRAC_BITS-2:0]};
        ay = {~in_cy[FRAC_BITS-1], in_cy[FRAC_BITS-2:0]};
    end

    // bank addressing for reads and the single write
    logic [BANK_AW-1:0]    rd_addr [NUM_BANKS];
    logic [BANK_AW-1:0]    wr_addr;
    logic [NUM_BANKS-1:0]  bank_we;
    t_idx                  wr_c, wr_r;
    always_comb begin
        t_idx csel, rsel;
        wr_c = in_col[IDX_W-1:0];
        wr_r = in_row[IDX_W-1:0];
        wr_addr = {wr_r[IDX_W-1:1], wr_c[IDX_W-1:1]};
        bank_we = '0;
        if (s_acc && in_op == OP_WRITE) begin
            bank_we[{wr_r[0], wr_c[0]}] = 1'b1;
        end
        for (int b = 0; b < NUM_BANKS; b++) begin
            csel = (x0[0] == b[0]) ? x0 : x1;
            rsel = (y0[0] == b[1]) ? y0 : y1;
            rd_addr[b] = {rsel[IDX_W-1:1], csel[IDX_W-1:1]};
        end
    end

    // texture banks, read data registered and held while stalled
    t_texel bank_rd [NUM_BANKS];
    for (genvar gb = 0; gb < NUM_BANKS; gb++) begin : g_bank
        t_texel mem [BANK_DEPTH];
        t_texel r_q;
        always_ff @(posedge i_clk) begin
            if (bank_we[gb]) begin
                mem[wr_addr] <= in_texel;
            end
            if (adv) begin
                r_q <= mem[rd_addr[gb]];
            end
        end
        assign bank_rd[gb] = r_q;
    end

    // stage 1 control: square parities and weights
    logic   r_v1;
    logic   r_x0p, r_y0p;
    t_alpha r_ax1, r_ay1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= s_acc && in_op == OP_SAMPLE;
        end
        if (adv) begin
            r_x0p <= x0[0];
            r_y0p <= y0[0];
            r_ax1 <= ax;
            r_ay1 <= ay;
        end
    end

    // corner routing and horizontal blend
    t_texel                 nw, ne, sw, se;
    logic                   n_eq;
    logic [N_W-1:0]         n_north [NUM_CH];
    logic [N_W-1:0]         n_south [NUM_CH];
    always_comb begin
        logic [CH_W-1:0]       ca, cb, cc, cd;
        logic signed [CH_W:0]  dn, ds;
        logic signed [H_W-1:0] hn, hs;
        nw   = bank_rd[{r_y0p,  r_x0p}];
        ne   = bank_rd[{r_y0p, ~r_x0p}];
        sw   = bank_rd[{~r_y0p,  r_x0p}];
        se   = bank_rd[{~r_y0p, ~r_x0p}];
        n_eq = (nw == ne) && (ne == sw) && (sw == se);
        for (int ch = 0; ch < NUM_CH; ch++) begin
            ca = nw[ch*CH_W +: CH_W];
            cb = ne[ch*CH_W +: CH_W];
            cc = sw[ch*CH_W +: CH_W];
            cd = se[ch*CH_W +: CH_W];
            dn = $signed({1'b0, cb}) - $signed({1'b0, ca});
            ds = $signed({1'b0, cd}) - $signed({1'b0, cc});
            hn = $signed({2'b00, ca, {FRAC_BITS{1'b0}}})
               + H_W'($signed({1'b0, r_ax1})) * H_W'(dn);
            hs = $signed({2'b00, cc, {FRAC_BITS{1'b0}}})
               + H_W'($signed({1'b0, r_ax1})) * H_W'(ds);
            n_north[ch] = hn[N_W-1:0];
            n_south[ch] = hs[N_W-1:0];
        end
    end

    logic           r_v2;
    logic           r_eq2;
    t_texel         r_sw2;
    t_alpha         r_ay2;
    logic [N_W-1:0] r_north2 [NUM_CH];
    logic [N_W-1:0] r_south2 [NUM_CH];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
        end
        if (adv) begin
            r_eq2 <= n_eq;
            r_sw2 <= sw;
            r_ay2 <= r_ay1;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_north2[ch] <= n_north[ch];
                r_south2[ch] <= n_south[ch];
            end
        end
    end

    // vertical weight times north-south difference
    logic signed [P_W-1:0] n_prod [NUM_CH];
    always_comb begin
        logic signed [D_W-1:0] dv;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            dv = $signed({1'b0, r_south2[ch]}) - $signed({1'b0, r_north2[ch]});
            n_prod[ch] = P_W'($signed({1'b0, r_ay2})) * P_W'(dv);
        end
    end

    logic                  r_v3;
    logic                  r_eq3;
    t_texel                r_sw3;
    logic [N_W-1:0]        r_north3 [NUM_CH];
    logic signed [P_W-1:0] r_prod3  [NUM_CH];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v3 <= r_v2;
        end
        if (adv) begin
            r_eq3 <= r_eq2;
            r_sw3 <= r_sw2;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_north3[ch] <= r_north2[ch];
                r_prod3[ch]  <= n_prod[ch];
            end
        end
    end

    // floor-shift add, channel extract and packing, or the whole texel when all four are equal
    t_texel n_pixel;
    always_comb begin
        logic signed [P_W-1:0] vsum;
        n_pixel = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            vsum = $signed({{(P_W-N_W){1'b0}}, r_north3[ch]}) + (r_prod3[ch] >>> FRAC_BITS);
            n_pixel[ch*CH_W +: CH_W] = vsum[FRAC_BITS +: CH_W];
        end
        if (r_eq3) begin
            n_pixel = r_sw3;
        end
    end

    // output register
    t_texel r_out_data;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_v3;
        end
        if (adv) begin
            r_out_data <= n_pixel;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // an accepted sample enters the pipe, a write does not
    a_sample_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_SAMPLE) |=> r_v1)
        else $error("accepted sample lost at stage 1");
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_WRITE) |=> !r_v1)
        else $error("write beat produced a pipeline item");
    // stall freezes the valid bits of stages 1 to 3
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> (r_v1 == $past(r_v1) && r_v2 == $past(r_v2) && r_v3 == $past(r_v3)))
        else $error("pipeline moved during stall");
    // last stage always lands in the output register
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && adv) |=> r_out_valid)
        else $error("sample dropped before output");
    // no write while the output is stalled
    a_no_write_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> (bank_we == '0))
        else $error("texture written during stall");
`endif

endmodule
